// ===== rtl/core/sync_length_checksum_deframer_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the frame parser
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_TOP_ASSERT_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLCD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slcd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SLCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slcd assertion failed");

`endif

// ===== rtl/core/slcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame parser package
// Types and fixed constants shared by the frame parser modules.
// ----------------------------------------------------------------------------
package slcd_pkg;

  // Sync pair that opens every frame.
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Payload length limit after reset.
  localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_PAYLOAD  = 2'd0,
    ST_GOOD     = 2'd1,
    ST_BAD_SUM  = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  // Parser phases, one-hot.
  typedef enum logic [8:0] {
    PH_HUNT1   = 9'b000000001,
    PH_HUNT2   = 9'b000000010,
    PH_CLASS   = 9'b000000100,
    PH_ID      = 9'b000001000,
    PH_LEN_LO  = 9'b000010000,
    PH_LEN_HI  = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CK_A    = 9'b010000000,
    PH_CK_B    = 9'b100000000
  } phase_t;

  // Result of one byte, handed from the parser to the output register.
  typedef struct packed {
    logic        emit;
    status_t     status;
    logic [7:0]  data;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic [15:0] frame_length;
  } result_t;

endpackage

// ===== rtl/core/slcd_if.sv =====
// ----------------------------------------------------------------------------
// Frame parser channel interfaces
// Valid/ready channels for the byte input, the result output and the limit.
// ----------------------------------------------------------------------------
interface slcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface slcd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  out_byte;
  logic [7:0]  frame_class;
  logic [7:0]  frame_id;
  logic [15:0] frame_length;

  modport source (output valid, output status, output out_byte, output frame_class,
                  output frame_id, output frame_length, input ready);
  modport sink (input valid, input status, input out_byte, input frame_class,
                input frame_id, input frame_length, output ready);
endinterface

interface slcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/slcd_parser.sv =====
// ----------------------------------------------------------------------------
// Frame parser state machine
// Tracks sync, header, payload and checksum phases and the Fletcher sums, and
// produces the result of the current byte combinationally.
// ----------------------------------------------------------------------------
`include "sync_length_checksum_deframer_top_assert.svh"

module slcd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv_i,
  input  logic [7:0]           byte_i,
  input  logic [15:0]          max_len_i,
  output slcd_pkg::result_t    res_o
);

  slcd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  rx_a_r, rx_a_nxt;
  logic [15:0] cnt_inc;
  logic [7:0]  sa_add;
  logic [7:0]  sb_add;

  // Running sums with the current byte folded in.
  assign cnt_inc = cnt_r + 16'd1;
  assign sa_add  = sum_a_r + byte_i;
  assign sb_add  = sum_b_r + sa_add;

  // Next state and result for the current byte.
  always_comb begin
    phase_nxt  = phase_r;
    class_nxt  = class_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    sum_a_nxt  = sum_a_r;
    sum_b_nxt  = sum_b_r;
    rx_a_nxt   = rx_a_r;
    res_o.emit   = 1'b0;
    res_o.status = slcd_pkg::ST_PAYLOAD;
    res_o.data   = 8'd0;
    unique case (phase_r)
      slcd_pkg::PH_HUNT2: begin
        if (byte_i == slcd_pkg::SYNC_SECOND) begin
          sum_a_nxt = 8'd0;
          sum_b_nxt = 8'd0;
          phase_nxt = slcd_pkg::PH_CLASS;
        end else if (byte_i != slcd_pkg::SYNC_FIRST) begin
          phase_nxt = slcd_pkg::PH_HUNT1;
        end
      end
      slcd_pkg::PH_CLASS: begin
        class_nxt = byte_i;
        sum_a_nxt = sa_add;
        sum_b_nxt = sb_add;
        phase_nxt = slcd_pkg::PH_ID;
      end
      slcd_pkg::PH_ID: begin
        id_nxt    = byte_i;
        sum_a_nxt = sa_add;
        sum_b_nxt = sb_add;
        phase_nxt = slcd_pkg::PH_LEN_LO;
      end
      slcd_pkg::PH_LEN_LO: begin
        len_nxt   = {8'd0, byte_i};
        sum_a_nxt = sa_add;
        sum_b_nxt = sb_add;
        phase_nxt = slcd_pkg::PH_LEN_HI;
      end
      slcd_pkg::PH_LEN_HI: begin
        len_nxt   = {byte_i, len_r[7:0]};
        sum_a_nxt = sa_add;
        sum_b_nxt = sb_add;
        cnt_nxt   = 16'd0;
        if (len_nxt > max_len_i) begin
          phase_nxt    = slcd_pkg::PH_HUNT1;
          res_o.emit   = 1'b1;
          res_o.status = slcd_pkg::ST_TOO_LONG;
        end else if (len_nxt == 16'd0) begin
          phase_nxt = slcd_pkg::PH_CK_A;
        end else begin
          phase_nxt = slcd_pkg::PH_PAYLOAD;
        end
      end
      slcd_pkg::PH_PAYLOAD: begin
        sum_a_nxt = sa_add;
        sum_b_nxt = sb_add;
        cnt_nxt   = cnt_inc;
        if (cnt_inc >= len_r) begin
          phase_nxt = slcd_pkg::PH_CK_A;
        end
        res_o.emit   = 1'b1;
        res_o.status = slcd_pkg::ST_PAYLOAD;
        res_o.data   = byte_i;
      end
      slcd_pkg::PH_CK_A: begin
        rx_a_nxt  = byte_i;
        phase_nxt = slcd_pkg::PH_CK_B;
      end
      slcd_pkg::PH_CK_B: begin
        phase_nxt  = slcd_pkg::PH_HUNT1;
        res_o.emit = 1'b1;
        if ((rx_a_r == sum_a_r) && (byte_i == sum_b_r)) begin
          res_o.status = slcd_pkg::ST_GOOD;
        end else begin
          res_o.status = slcd_pkg::ST_BAD_SUM;
        end
      end
      default: begin
        // Hunting for the first sync byte, also any unexpected phase code.
        phase_nxt = (byte_i == slcd_pkg::SYNC_FIRST) ? slcd_pkg::PH_HUNT2
                                                       : slcd_pkg::PH_HUNT1;
      end
    endcase
    res_o.frame_class  = class_nxt;
    res_o.frame_id     = id_nxt;
    res_o.frame_length = len_nxt;
  end

  // State registers advance once per accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= slcd_pkg::PH_HUNT1;
      class_r <= 8'd0;
      id_r    <= 8'd0;
      len_r   <= 16'd0;
      cnt_r   <= 16'd0;
      sum_a_r <= 8'd0;
      sum_b_r <= 8'd0;
      rx_a_r  <= 8'd0;
    end else if (adv_i) begin
      phase_r <= phase_nxt;
      class_r <= class_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      rx_a_r  <= rx_a_nxt;
    end
  end

  // Payload results come only from the payload phase.
  `SLCD_ASSERT_NOW(a_payload_phase, res_o.emit && (res_o.status == slcd_pkg::ST_PAYLOAD), phase_r == slcd_pkg::PH_PAYLOAD)
  // A rejected length really exceeds the limit.
  `SLCD_ASSERT_NOW(a_too_long_len, res_o.emit && (res_o.status == slcd_pkg::ST_TOO_LONG), len_nxt > max_len_i)
  // The last payload byte leads to the first checksum byte.
  `SLCD_ASSERT_NEXT(a_payload_end, adv_i && (phase_r == slcd_pkg::PH_PAYLOAD) && (cnt_inc >= len_r), phase_r == slcd_pkg::PH_CK_A)
  // The second checksum byte always returns to the hunt.
  `SLCD_ASSERT_NEXT(a_ck_b_done, adv_i && (phase_r == slcd_pkg::PH_CK_B), phase_r == slcd_pkg::PH_HUNT1)

endmodule

// ===== rtl/core/sync_length_checksum_deframer_top.sv =====
// A result is presented in the cycle after the byte that causes it is transferred.
// Throughput: one byte per cycle; the single output register is reloaded in the
// cycle it is taken, so the input stalls only while a result waits unaccepted.
// Reset (rst_n low, synchronous) returns the parser to the sync hunt, empties the
// output register and sets the payload length limit to 1024.
// ----------------------------------------------------------------------------
// Frame parser top level
// Finds sync-framed packets in a byte stream, passes payload bytes out and
// reports a good, bad-checksum or too-long status per frame.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_top (
  input  logic           clk,
  input  logic           rst_n,
  slcd_in_if.sink        in_ch,
  slcd_out_if.source     out_ch,
  slcd_cfg_if.sink       cfg_ch
);

  logic              in_fire;
  logic              out_valid_r;
  logic [15:0]       max_len_r;
  slcd_pkg::result_t res;
  slcd_pkg::result_t res_r;

  // Input is taken whenever the output register is free or being emptied.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Limit register, always writable.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= slcd_pkg::MAX_LEN_RESET;
    end else if (cfg_ch.valid) begin
      max_len_r <= cfg_ch.data;
    end
  end

  slcd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv_i     (in_fire),
    .byte_i    (in_ch.in_byte),
    .max_len_i (max_len_r),
    .res_o     (res)
  );

  // Output register: valid flag under reset, payload loaded on a result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res.emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res.emit) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = res_r.status;
  assign out_ch.out_byte     = res_r.data;
  assign out_ch.frame_class  = res_r.frame_class;
  assign out_ch.frame_id     = res_r.frame_id;
  assign out_ch.frame_length = res_r.frame_length;

endmodule
